FILE: rtl/core/url_percent_decoder_unit_macros.svh
// assertion macros shared by the url percent decoder rtl
`ifndef URL_PERCENT_DECODER_UNIT_MACROS_SVH
`define URL_PERCENT_DECODER_UNIT_MACROS_SVH

// concurrent check on an explicit clock and synchronous reset
`define UPD_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check on the block clock and reset
`define UPD_ASSERT(label, prop, msg) \
   `UPD_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

FILE: rtl/core/upd_pkg.sv
// types, character codes and hex helpers for the url percent decoder
`default_nettype none

package upd_pkg;

   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // escape tracking state
   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_PCT  = 2'd1,
      MODE_HEX  = 2'd2
   } mode_type;

   // up to three decoded bytes from one request, slot 0 goes out first
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] data;
      logic            last;
   } burst_type;

   typedef struct packed {
      burst_type  burst;
      mode_type   mode_next;
      logic [7:0] held_next;
   } decode_type;

   function automatic logic hex_ok(input logic [7:0] c);
      hex_ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] v;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = c - 8'h37;
      end else begin
         v = c - 8'h57;
      end
      hex_nibble = v[3:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/upd_decode.sv
// combinational decode of one byte against the pending escape state
`default_nettype none

module upd_decode (
   input  wire logic [7:0]          byte_in,
   input  wire logic                last_in,
   input  wire upd_pkg::mode_type   mode,
   input  wire logic [7:0]          held,
   output upd_pkg::decode_type      dec
);
   import upd_pkg::*;

   logic       cur_pct;
   logic       cur_pend;
   logic [7:0] cur_val;
   logic       cur_hex;

   // plain handling of the new byte
   assign cur_pct  = (byte_in == CHAR_PCT);
   assign cur_pend = cur_pct && !last_in;
   assign cur_val  = (byte_in == CHAR_PLUS) ? CHAR_SPACE : byte_in;
   assign cur_hex  = hex_ok(byte_in);

   always_comb begin
      dec.burst.count = 2'd0;
      dec.burst.data  = '0;
      dec.burst.last  = last_in;
      dec.mode_next   = MODE_IDLE;
      dec.held_next   = held;
      case (mode)
         MODE_PCT: begin
            if (cur_hex && !last_in) begin
               dec.held_next = byte_in;
               dec.mode_next = MODE_HEX;
            end else begin
               dec.burst.data[0] = CHAR_PCT;
               dec.burst.data[1] = cur_val;
               dec.burst.count   = cur_pend ? 2'd1 : 2'd2;
               dec.mode_next     = cur_pend ? MODE_PCT : MODE_IDLE;
            end
         end
         MODE_HEX: begin
            if (cur_hex) begin
               dec.burst.data[0] = {hex_nibble(held), hex_nibble(byte_in)};
               dec.burst.count   = 2'd1;
            end else begin
               // broken escape: percent, held digit, then the new byte
               dec.burst.data[0] = CHAR_PCT;
               dec.burst.data[1] = held;
               dec.burst.data[2] = cur_val;
               dec.burst.count   = cur_pend ? 2'd2 : 2'd3;
               dec.mode_next     = cur_pend ? MODE_PCT : MODE_IDLE;
            end
         end
         default: begin
            if (cur_pend) begin
               dec.mode_next = MODE_PCT;
            end else begin
               dec.burst.data[0] = cur_val;
               dec.burst.count   = 2'd1;
            end
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/core/upd_burst.sv
// result register that plays out a burst of up to three bytes
`default_nettype none

module upd_burst (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire upd_pkg::burst_type ld,
   output logic                    free,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_run_last,
   output logic                    rsp_msg_end
);
   import upd_pkg::*;

   logic [1:0]      remain_ff, remain_in;
   logic [2:0][7:0] data_ff, data_in;
   logic            last_ff, last_in;
   logic            emit;

   assign emit = (remain_ff != 2'd0) && !rsp_stall;
   assign free = (remain_ff == 2'd0) || ((remain_ff == 2'd1) && !rsp_stall);

   assign rsp_valid    = (remain_ff != 2'd0);
   assign rsp_out_byte = data_ff[0];
   assign rsp_run_last = (remain_ff == 2'd1);
   assign rsp_msg_end  = (remain_ff == 2'd1) && last_ff;

   always_comb begin
      remain_in = remain_ff;
      data_in   = data_ff;
      last_in   = last_ff;
      if (load) begin
         remain_in = ld.count;
         data_in   = ld.data;
         last_in   = ld.last;
      end else if (emit) begin
         remain_in = remain_ff - 2'd1;
         data_in   = {8'h00, data_ff[2], data_ff[1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= 2'd0;
      end else begin
         remain_ff <= remain_in;
      end
      data_ff <= data_in;
      last_ff <= last_in;
   end

endmodule

`default_nettype wire

FILE: rtl/core/url_percent_decoder_unit.sv
// top level of the streaming url percent decoder
//
// usage:
//  - req channel carries one encoded byte per request (req_in_byte) and a
//    flag marking the final byte of a message (req_in_last)
//  - rsp channel carries one decoded byte per response; rsp_run_last marks
//    the last byte caused by a request, rsp_msg_end the last byte of a message
//  - a request is taken when valid is high and stall is low, on both sides
//  - path: a taken request goes into the input register, is decoded
//    combinationally and moves on into the result register once it is free
//  - throughput: one request per cycle while each produces at most one byte
//    and rsp_stall is low; a request producing more holds the result register
//    until all are out (up to three on broken escape or end-of-message flush)
//  - a percent sign and one hex digit produce nothing until the next byte
//    decides them; the final byte of a message always flushes them
//  - when the receiver stalls, the result register holds its byte and the
//    input register fills, then req_stall rises
//  - synchronous reset empties both registers and clears the pending escape
`default_nettype none

`include "url_percent_decoder_unit_macros.svh"

module url_percent_decoder_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_run_last,
   output logic            rsp_msg_end
);
   import upd_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // pending escape state
   mode_type   mode_ff, mode_in;
   logic [7:0] held_ff, held_in;

   decode_type dec;
   logic       accept;
   logic       consume;
   logic       burst_free;
   logic       burst_load;

   upd_decode u_decode (
      .byte_in (in_byte_ff),
      .last_in (in_last_ff),
      .mode    (mode_ff),
      .held    (held_ff),
      .dec     (dec)
   );

   // a request that yields no byte retires without touching the result side
   assign consume    = in_valid_ff && ((dec.burst.count == 2'd0) || burst_free);
   assign burst_load = consume && (dec.burst.count != 2'd0);
   assign req_stall  = in_valid_ff && !consume;
   assign accept     = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
      mode_in = mode_ff;
      held_in = held_ff;
      if (consume) begin
         mode_in = dec.mode_next;
         held_in = dec.held_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
         held_ff     <= 8'h00;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
         held_ff     <= held_in;
      end
      if (accept) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_in_last;
      end
   end

   upd_burst u_burst (
      .clock        (clock),
      .reset        (reset),
      .load         (burst_load),
      .ld           (dec.burst),
      .free         (burst_free),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last),
      .rsp_msg_end  (rsp_msg_end)
   );

   // end of message leaves nothing pending
   `UPD_ASSERT(a_last_clears_mode, consume && in_last_ff |=> mode_ff == MODE_IDLE, "escape left pending after message end")
   // a held digit is always a hex digit
   `UPD_ASSERT(a_held_is_hex, mode_ff == MODE_HEX |-> hex_ok(held_ff), "held byte is not a hex digit")
   // message end only on the final byte of a request
   `UPD_ASSERT(a_end_on_run_last, rsp_valid && rsp_msg_end |-> rsp_run_last, "message end inside a run")

endmodule

`default_nettype wire

FILE: bench/url_percent_decoder_checker.sv
// predicts decoded bytes for each accepted request and checks the response channel against them
module url_percent_decoder_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_stall,
   input  wire logic [7:0] rsp_out_byte,
   input  wire logic       rsp_run_last,
   input  wire logic       rsp_msg_end,
   output int              error_count,
   output int              bytes_due
);
   import upd_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       run_last;
      logic       msg_end;
   } decoded_byte_type;

   mode_type         escape_mode;
   logic [7:0]       held_digit;
   logic [7:0]       burst_q[$];
   decoded_byte_type expected_q[$];
   int               errors;

   function automatic int hex_digit(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - 48;
      if (c >= "A" && c <= "F") return int'(c) - 55;
      if (c >= "a" && c <= "f") return int'(c) - 87;
      return -1;
   endfunction

   // one byte with no escape open
   task automatic push_plain(input logic [7:0] b, input logic last);
      if (b == CHAR_PCT) begin
         if (last) begin
            burst_q.push_back(CHAR_PCT);
         end else begin
            escape_mode = MODE_PCT;
         end
      end else if (b == CHAR_PLUS) begin
         burst_q.push_back(CHAR_SPACE);
      end else begin
         burst_q.push_back(b);
      end
   endtask

   task automatic decode_request(input logic [7:0] b, input logic last);
      mode_type         was_mode;
      int               hv;
      int               hh;
      decoded_byte_type entry;
      was_mode    = escape_mode;
      hv          = hex_digit(b);
      escape_mode = MODE_IDLE;
      burst_q.delete();
      case (was_mode)
         MODE_PCT: begin
            if (hv >= 0 && !last) begin
               held_digit  = b;
               escape_mode = MODE_HEX;
            end else begin
               burst_q.push_back(CHAR_PCT);
               push_plain(b, last);
            end
         end
         MODE_HEX: begin
            hh = hex_digit(held_digit);
            if (hv >= 0 && hh >= 0) begin
               burst_q.push_back(8'((hh << 4) | hv));
            end else begin
               burst_q.push_back(CHAR_PCT);
               push_plain(held_digit, 1'b0);
               push_plain(b, last);
            end
         end
         default: begin
            push_plain(b, last);
         end
      endcase
      foreach (burst_q[i]) begin
         entry.data     = burst_q[i];
         entry.run_last = (i == burst_q.size() - 1);
         entry.msg_end  = last && (i == burst_q.size() - 1);
         expected_q.push_back(entry);
      end
   endtask

   always @(posedge clock) begin
      decoded_byte_type want;
      if (reset) begin
         escape_mode = MODE_IDLE;
         held_digit  = '0;
         expected_q.delete();
         errors      = 0;
         error_count <= 0;
         bytes_due   <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_request(req_in_byte, req_in_last);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected byte %h, nothing expected", $time, rsp_out_byte);
            end else begin
               want = expected_q.pop_front();
               if (rsp_out_byte !== want.data) begin
                  errors++;
                  $display("%0t: out_byte expected %h actual %h",
                           $time, want.data, rsp_out_byte);
               end
               if (rsp_run_last !== want.run_last) begin
                  errors++;
                  $display("%0t: run_last expected %b actual %b",
                           $time, want.run_last, rsp_run_last);
               end
               if (rsp_msg_end !== want.msg_end) begin
                  errors++;
                  $display("%0t: msg_end expected %b actual %b",
                           $time, want.msg_end, rsp_msg_end);
               end
            end
         end
         error_count <= errors;
         bytes_due   <= expected_q.size();
      end
   end

endmodule

FILE: bench/tb_url_percent_decoder_unit.sv
// top of the url percent decoder bench: clock, reset, request and stall stimulus, verdict
module tb_url_percent_decoder_unit;
   import upd_pkg::*;

   // random request count, hard cycle limit and drain time after the last byte
   localparam int RANDOM_ITEMS = 430;
   localparam int LIMIT_CYCLES = 200000;
   localparam int TAIL_CYCLES  = 20;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_in_byte;
   logic       req_in_last;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;
   logic       rsp_msg_end;

   int error_count;
   int bytes_due;
   int sent_count  = 0;
   int cycle_count = 0;

   // per-message and per-stretch switches that turn idling off for a while
   bit gapless = 1'b0;
   bit steady  = 1'b0;

   url_percent_decoder_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last),
      .rsp_msg_end  (rsp_msg_end)
   );

   url_percent_decoder_checker u_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last),
      .rsp_msg_end  (rsp_msg_end),
      .error_count  (error_count),
      .bytes_due    (bytes_due)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // hard stop in case the handshake hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [7:0] hex_char();
      string digits;
      digits = "0123456789ABCDEFabcdef";
      return digits[$urandom_range(0, 21)];
   endfunction

   // bytes that never count as hex digits, including the two special ones
   function automatic logic [7:0] odd_char();
      string odd;
      odd = "gGz.%+/ ~";
      return odd[$urandom_range(0, 8)];
   endfunction

   // one request: optional idle gap, then hold valid and payload until taken
   task automatic send_request(input logic [7:0] b, input logic last);
      int gap;
      gap = gapless ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   task automatic send_message(input string text);
      for (int i = 0; i < text.len(); i++) begin
         send_request(text[i], i == text.len() - 1);
      end
   endtask

   // well-formed escapes with random digits in four draws of ten, mixed with plus signs,
   // broken escapes, lone percent signs and arbitrary bytes
   task automatic random_message();
      logic [7:0] body[$];
      int         len;
      int         kind;
      len     = $urandom_range(1, 10);
      gapless = ($urandom_range(0, 4) == 0);
      while (body.size() < len) begin
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1, 2, 3: begin
               body.push_back(CHAR_PCT);
               body.push_back(hex_char());
               body.push_back(hex_char());
            end
            4: begin
               body.push_back(CHAR_PLUS);
            end
            5: begin
               // percent and one digit, then something that breaks it
               body.push_back(CHAR_PCT);
               body.push_back(hex_char());
               body.push_back(odd_char());
            end
            6: begin
               body.push_back(CHAR_PCT);
               body.push_back(odd_char());
            end
            default: begin
               body.push_back(8'($urandom_range(0, 255)));
            end
         endcase
      end
      foreach (body[i]) begin
         send_request(body[i], i == body.size() - 1);
      end
   endtask

   // receiver: random stall before each response, with quiet stretches
   initial begin
      int hold;
      rsp_stall <= 1'b0;
      forever begin
         hold = steady ? 0 : $urandom_range(0, 3);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         if ($urandom_range(0, 29) == 0) begin
            steady = !steady;
         end
      end
   end

   initial begin
      int random_start;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_in_byte <= '0;
      req_in_last <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: plain escape, plus, broken escape, both hex cases
      send_message("%41");
      send_message("a+b");
      send_message("%4g");
      send_message("%ff%Fa");
      // percent signs near the end of a message are flushed undecoded
      send_message("%%");
      send_message("%4");
      send_message("%");
      // single broken escape, then a trailing percent
      send_message("%g%");
      send_message("%+");
      // byte extremes
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'h80, 1'b1);

      random_start = sent_count;
      while (sent_count - random_start < RANDOM_ITEMS) begin
         random_message();
      end
      req_valid <= 1'b0;

      // drain: every predicted byte must come out, then a short quiet tail
      @(posedge clock);
      while (bytes_due != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
